// ===== design/tfm_pkg.sv =====
// ----------------------------------------------------------------------------
// tfm_pkg
// Command codes and wildcard characters for the topic filter matcher.
// ----------------------------------------------------------------------------
package tfm_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TOPIC  = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

endpackage

// ===== design/tfm_ram.sv =====
// ----------------------------------------------------------------------------
// tfm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== design/topic_filter_match.sv =====
// ----------------------------------------------------------------------------
// topic_filter_match
// Matches streamed topic names against a stored subscription filter with
// single-level and multi-level wildcards.
// ----------------------------------------------------------------------------
//  channel  | dir | tuser        | tdata                                  | tlast
//  s_axis   | in  | [1:0] cmd    | [7:0] ch                               | -
//  m_axis   | out | -            | [0] match, [1] filter_overflow, [7:2] 0 | -
//
// no new transaction is taken while one sits in the pipeline stage: the filter
// ram is read at the walk position and the one after it, and the next walk
// position is known only once that registered read data has been evaluated.
// one result per topic end, held in an output register; input keeps flowing
// while that result waits, until another topic end reaches evaluation.
// arst_n clears the filter length, the walk and the overflow flag; the filter
// ram itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module topic_filter_match #(
	parameter int MAX_FILTER_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [0] match, [1] filter_overflow
);

	import tfm_pkg::*;

	localparam int AW = $clog2(MAX_FILTER_LEN);
	localparam int LW = $clog2(MAX_FILTER_LEN + 1);

	// pipeline stage
	logic          valid_s1;
	cmd_t          cmd_s1;
	logic [7:0]    ch_s1;

	// walk state
	logic [LW-1:0] len_q;
	logic [LW-1:0] walk_q;
	logic [7:0]    prev_q;
	logic          plus_q;
	logic          dec_q;
	logic          dv_q;
	logic          ovf_q;

	// output register
	logic          out_valid_q;
	logic          out_match_q;
	logic          out_ovf_q;

	logic [7:0]    cur;
	logic [7:0]    nxt;
	logic [LW:0]   len_e;
	logic [LW:0]   w1;
	logic [LW:0]   w2;
	logic          in_acc;
	logic          advance;
	logic          ram_we;

	logic [LW-1:0] len_n;
	logic [LW-1:0] walk_n;
	logic [7:0]    prev_n;
	logic          plus_n;
	logic          dec_n;
	logic          dv_n;
	logic          ovf_n;
	logic          end_match;

	assign s_axis_tready = !valid_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign advance       = valid_s1 &&
		!(cmd_s1 == CMD_END && out_valid_q && !m_axis_tready);
	assign ram_we        = valid_s1 && cmd_s1 == CMD_APPEND &&
		len_q < LW'(MAX_FILTER_LEN);

	assign len_e = {1'b0, len_q};
	assign w1    = {1'b0, walk_q} + (LW+1)'(1);
	assign w2    = {1'b0, walk_q} + (LW+1)'(2);

	// read address follows the walk position every cycle
	tfm_ram #(
		.WIDTH (8),
		.DEPTH (MAX_FILTER_LEN),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (len_q[AW-1:0]),
		.wdata   (ch_s1),
		.raddr_a (walk_q[AW-1:0]),
		.rdata_a (cur),
		.raddr_b (w1[AW-1:0]),
		.rdata_b (nxt)
	);

	always_comb begin
		len_n     = len_q;
		walk_n    = walk_q;
		prev_n    = prev_q;
		plus_n    = plus_q;
		dec_n     = dec_q;
		dv_n      = dv_q;
		ovf_n     = ovf_q;
		end_match = 1'b0;
		unique case (cmd_s1)
			CMD_CLEAR: begin
				len_n  = '0;
				ovf_n  = 1'b0;
				walk_n = '0;
				plus_n = 1'b0;
				dec_n  = 1'b0;
				dv_n   = 1'b0;
			end
			CMD_APPEND: begin
				if (len_q < LW'(MAX_FILTER_LEN)) begin
					len_n = len_q + LW'(1);
				end else begin
					ovf_n = 1'b1;
				end
			end
			CMD_TOPIC: begin
				// a pending '+' swallows everything up to the next level separator
				if (!dec_q && !(plus_q && ch_s1 != CH_SLASH)) begin
					plus_n = 1'b0;
					if (walk_q >= len_q) begin
						dec_n = 1'b1;
						dv_n  = 1'b0;
					end else if (cur == CH_HASH) begin
						dec_n = 1'b1;
						dv_n  = (w1 == len_e) && (walk_q == '0 || prev_q == CH_SLASH);
					end else if (cur == CH_PLUS) begin
						if ((walk_q != '0 && prev_q != CH_SLASH) ||
							(w1 < len_e && nxt != CH_SLASH)) begin
							dec_n = 1'b1;
							dv_n  = 1'b0;
						end else if (ch_s1 == CH_SLASH) begin
							// empty level: the '/' after the '+' is consumed too
							if (w1 >= len_e) begin
								dec_n = 1'b1;
								dv_n  = 1'b0;
							end else begin
								walk_n = w2[LW-1:0];
								prev_n = CH_SLASH;
							end
						end else begin
							walk_n = w1[LW-1:0];
							prev_n = CH_PLUS;
							plus_n = 1'b1;
						end
					end else if (cur == ch_s1) begin
						walk_n = w1[LW-1:0];
						prev_n = cur;
					end else begin
						dec_n = 1'b1;
						dv_n  = 1'b0;
					end
				end
			end
			CMD_END: begin
				if (dec_q) begin
					end_match = dv_q;
				end else if (walk_q < len_q) begin
					if (cur == CH_HASH) begin
						end_match = 1'b1;
					end else begin
						end_match = (w2 == len_e) && cur == CH_SLASH && nxt == CH_HASH;
					end
				end else begin
					end_match = 1'b1;
				end
				walk_n = '0;
				plus_n = 1'b0;
				dec_n  = 1'b0;
				dv_n   = 1'b0;
			end
			default: begin
				len_n = len_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			len_q       <= '0;
			walk_q      <= '0;
			plus_q      <= 1'b0;
			dec_q       <= 1'b0;
			dv_q        <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				len_q  <= len_n;
				walk_q <= walk_n;
				plus_q <= plus_n;
				dec_q  <= dec_n;
				dv_q   <= dv_n;
				ovf_q  <= ovf_n;
			end
			if (advance && cmd_s1 == CMD_END) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= cmd_t'(s_axis_tuser);
			ch_s1  <= s_axis_tdata;
		end
		if (advance) begin
			prev_q <= prev_n;
		end
		if (advance && cmd_s1 == CMD_END) begin
			out_match_q <= end_match;
			out_ovf_q   <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_ovf_q, out_match_q};

`ifndef SYNTHESIS
	a_walk_in_filter: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q <= len_q)
		else $error("walk position beyond filter length");

	a_plus_undecided: assert property (@(posedge clk) disable iff (!arst_n)
		!(plus_q && dec_q))
		else $error("inside a plus level with outcome already fixed");

	a_plus_prev: assert property (@(posedge clk) disable iff (!arst_n)
		plus_q |-> (walk_q != '0 && prev_q == CH_PLUS))
		else $error("plus level without a plus behind the walk");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_s1 == CMD_END) |=> m_axis_tvalid)
		else $error("topic end produced no result");
`endif

endmodule
